### src/triangle_barycentric_shade_top_assert.svh
// assertion macros for the triangle barycentric shader
// expects clk and rst_n in the scope of the including module
`ifndef TRIANGLE_BARYCENTRIC_SHADE_TOP_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_SHADE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TBS_ASSERT_IMP(lbl, ante, cons)
`define TBS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/tbs_pkg.sv
// widths, limits and register codes for the triangle barycentric shader
// no dependencies
`default_nettype none
package tbs_pkg;
    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int NUM_W       = PROD_W + 2;
    localparam int WEIGHT_W    = FRAC_BITS + 2;
    localparam int DIV_W       = NUM_W + WEIGHT_W + 1;
    localparam int DIV_LAT     = WEIGHT_W + 2;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int CPROD_W     = CH_W + 1 + WEIGHT_W;
    localparam int SUM_W       = CPROD_W + 2;
    localparam int VERT_W      = 2 * COORD_BITS;
    localparam int COLOR_W     = NUM_CH * CH_W;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * WEIGHT_W + NUM_CH * CH_W + 7) / 8) * 8;

    localparam logic [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_A = 3'd0,
        REG_VERTEX_B = 3'd1,
        REG_VERTEX_C = 3'd2,
        REG_COLOR_A  = 3'd3,
        REG_COLOR_B  = 3'd4,
        REG_COLOR_C  = 3'd5
    } cfg_index_t;
endpackage
`default_nettype wire

### src/tbs_div.sv
// pipelined restoring divider for one weight, one quotient bit per stage
// depends on tbs_pkg
`default_nettype none
module tbs_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [tbs_pkg::NUM_W-1:0]     num_mag,
    input  wire logic [tbs_pkg::NUM_W-1:0]     den_mag,
    input  wire logic                          neg,
    output logic signed [tbs_pkg::WEIGHT_W-1:0] weight
);
    import tbs_pkg::*;

    logic [DIV_W-1:0]    rem_reg [WEIGHT_W+1];
    logic [NUM_W-1:0]    md_reg  [WEIGHT_W+1];
    logic [WEIGHT_W-1:0] q_reg   [WEIGHT_W+1];
    logic                sat_reg [WEIGHT_W+1];
    logic                neg_reg [WEIGHT_W+1];
    logic [DIV_W-1:0]    dividend;
    logic [DIV_W-1:0]    den_top;
    logic [WEIGHT_W-1:0] q_fin;
    logic signed [WEIGHT_W-1:0] weight_reg;

    assign dividend = DIV_W'({num_mag, {FRAC_BITS{1'b0}}}) + DIV_W'(den_mag >> 1);
    assign den_top  = DIV_W'({den_mag, {WEIGHT_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dividend;
            md_reg[0]  <= den_mag;
            q_reg[0]   <= '0;
            sat_reg[0] <= (dividend >= den_top);
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 0; k < WEIGHT_W; k++)
    begin : g_stage
        localparam int B = WEIGHT_W - 1 - k;
        logic [DIV_W-1:0] dsh;
        logic             ge;
        assign dsh = DIV_W'(md_reg[k]) << B;
        assign ge  = (rem_reg[k] >= dsh);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]    <= ge ? rem_reg[k] - dsh : rem_reg[k];
                md_reg[k+1]     <= md_reg[k];
                q_reg[k+1]      <= q_reg[k] | (ge ? (WEIGHT_W'(1) << B) : '0);
                sat_reg[k+1]    <= sat_reg[k];
                neg_reg[k+1]    <= neg_reg[k];
            end
        end
    end

    assign q_fin = q_reg[WEIGHT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[WEIGHT_W])
            begin
                if (sat_reg[WEIGHT_W] || q_fin > W_MIN)
                    weight_reg <= W_MIN;
                else
                    weight_reg <= -q_fin;
            end
            else
            begin
                if (sat_reg[WEIGHT_W] || q_fin > W_MAX)
                    weight_reg <= W_MAX;
                else
                    weight_reg <= q_fin;
            end
        end
    end

    assign weight = weight_reg;
endmodule
`default_nettype wire

### src/triangle_barycentric_shade_top.sv
// barycentric weights and colour interpolation for one configured triangle
// depends on tbs_pkg, tbs_div and triangle_barycentric_shade_top_assert.svh
//
// channel  direction  contents
// s_axis   in         tdata: pixel_x, pixel_y
// m_axis   out        tdata: weights alpha, beta, gamma, red, green, blue, fourth; tuser: degenerate
// cfg      in         cfg_index, cfg_data, always ready
//
// one pixel enters per cycle while m_axis is not stalled; the pipeline holds 3 front stages,
// 20 divider stages, channel products and output
// the divider pipeline, one quotient bit per stage, sets the depth
// reset clears valid bits and configuration registers
// a stall on m_axis holds every stage and drops tready in the same cycle
`default_nettype none
`include "triangle_barycentric_shade_top_assert.svh"
module triangle_barycentric_shade_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // pixel_x, pixel_y
    input  wire logic [tbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // weight_alpha, weight_beta, weight_gamma, red, green, blue, fourth
    output logic [tbs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // degenerate
    output logic [0:0]                              m_axis_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                        cfg_data
);
    import tbs_pkg::*;

    logic [VERT_W-1:0]  vertex_a_reg, vertex_b_reg, vertex_c_reg;
    logic [COLOR_W-1:0] color_a_reg, color_b_reg, color_c_reg;

    logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy;
    logic signed [DIFF_W-1:0] t_acx_reg, t_acy_reg, t_bax_reg, t_bay_reg;
    logic signed [PROD_W:0]   d_reg;
    logic [NUM_W-1:0]         md_reg;
    logic                     dneg_reg;
    logic                     dzero_reg;

    logic en, in_acc;

    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dpxc_reg, dpyc_reg, dpxa_reg, dpya_reg;
    logic                     v2_reg;
    logic signed [PROD_W:0]   nb_reg, ng_reg;
    logic                     v3_reg;
    logic [NUM_W-1:0]         mag_reg [3];
    logic                     neg_reg [3];
    logic                     deg3_reg;
    logic signed [NUM_W-1:0]  na_full, nb_full, ng_full;

    logic                     v_div_reg [DIV_LAT];
    logic                     deg_div_reg [DIV_LAT];
    logic signed [WEIGHT_W-1:0] w_div [3];

    logic                     v5_reg, deg5_reg;
    logic signed [WEIGHT_W-1:0] w5_reg [3];
    logic signed [CPROD_W-1:0]  cp_reg [NUM_CH][3];

    logic                     out_valid_reg, out_deg_reg;
    logic signed [WEIGHT_W-1:0] out_w_reg [3];
    logic [CH_W-1:0]          out_ch_reg [NUM_CH];
    logic [CH_W-1:0]          ch_next [NUM_CH];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_a_reg <= '0;
            vertex_b_reg <= '0;
            vertex_c_reg <= '0;
            color_a_reg  <= '0;
            color_b_reg  <= '0;
            color_c_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VERTEX_A: vertex_a_reg <= cfg_data[VERT_W-1:0];
                REG_VERTEX_B: vertex_b_reg <= cfg_data[VERT_W-1:0];
                REG_VERTEX_C: vertex_c_reg <= cfg_data[VERT_W-1:0];
                REG_COLOR_A:  color_a_reg  <= cfg_data[COLOR_W-1:0];
                REG_COLOR_B:  color_b_reg  <= cfg_data[COLOR_W-1:0];
                REG_COLOR_C:  color_c_reg  <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign ax = $signed({1'b0, vertex_a_reg[COORD_BITS-1:0]});
    assign ay = $signed({1'b0, vertex_a_reg[VERT_W-1:COORD_BITS]});
    assign bx = $signed({1'b0, vertex_b_reg[COORD_BITS-1:0]});
    assign by = $signed({1'b0, vertex_b_reg[VERT_W-1:COORD_BITS]});
    assign cx = $signed({1'b0, vertex_c_reg[COORD_BITS-1:0]});
    assign cy = $signed({1'b0, vertex_c_reg[VERT_W-1:COORD_BITS]});

    // triangle terms follow the registers, settled by the time the first item after a write
    // reaches them
    always_ff @(posedge clk)
    begin
        t_acx_reg <= ax - cx;
        t_acy_reg <= ay - cy;
        t_bax_reg <= bx - ax;
        t_bay_reg <= by - ay;
        d_reg     <= (PROD_W+1)'((bx - ax) * (cy - ay)) - (PROD_W+1)'((by - ay) * (cx - ax));
        md_reg    <= d_reg[PROD_W] ? NUM_W'(-d_reg) : NUM_W'(d_reg);
        dneg_reg  <= d_reg[PROD_W];
        dzero_reg <= (d_reg == '0);
    end

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign na_full = NUM_W'($signed(d_reg)) - NUM_W'(nb_reg) - NUM_W'(ng_reg);
    assign nb_full = NUM_W'(nb_reg);
    assign ng_full = NUM_W'(ng_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpxc_reg <= $signed({1'b0, s_axis_tdata[COORD_BITS-1:0]}) - cx;
            dpyc_reg <= $signed({1'b0, s_axis_tdata[VERT_W-1:COORD_BITS]}) - cy;
            dpxa_reg <= $signed({1'b0, s_axis_tdata[COORD_BITS-1:0]}) - ax;
            dpya_reg <= $signed({1'b0, s_axis_tdata[VERT_W-1:COORD_BITS]}) - ay;
            nb_reg   <= (PROD_W+1)'(t_acx_reg * dpyc_reg) - (PROD_W+1)'(dpxc_reg * t_acy_reg);
            ng_reg   <= (PROD_W+1)'(t_bax_reg * dpya_reg) - (PROD_W+1)'(dpxa_reg * t_bay_reg);
            mag_reg[0] <= na_full[NUM_W-1] ? NUM_W'(-na_full) : NUM_W'(na_full);
            mag_reg[1] <= nb_full[NUM_W-1] ? NUM_W'(-nb_full) : NUM_W'(nb_full);
            mag_reg[2] <= ng_full[NUM_W-1] ? NUM_W'(-ng_full) : NUM_W'(ng_full);
            neg_reg[0] <= na_full[NUM_W-1] ^ dneg_reg;
            neg_reg[1] <= nb_full[NUM_W-1] ^ dneg_reg;
            neg_reg[2] <= ng_full[NUM_W-1] ^ dneg_reg;
            deg3_reg   <= dzero_reg;
        end
    end

    for (genvar w = 0; w < 3; w++)
    begin : g_div
        tbs_div u_div (
            .clk     (clk),
            .en      (en),
            .num_mag (mag_reg[w]),
            .den_mag (md_reg),
            .neg     (neg_reg[w]),
            .weight  (w_div[w])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                v_div_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_div_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_LAT; i++)
                v_div_reg[i] <= v_div_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_div_reg[0] <= deg3_reg;
            for (int i = 1; i < DIV_LAT; i++)
                deg_div_reg[i] <= deg_div_reg[i-1];
        end
    end

    // channel products, red in the top byte of each colour
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg5_reg <= deg_div_reg[DIV_LAT-1];
            for (int w = 0; w < 3; w++)
                w5_reg[w] <= w_div[w];
            for (int c = 0; c < NUM_CH; c++)
            begin
                cp_reg[c][0] <= $signed({1'b0, color_a_reg[CH_W*(NUM_CH-1-c) +: CH_W]}) * w_div[0];
                cp_reg[c][1] <= $signed({1'b0, color_b_reg[CH_W*(NUM_CH-1-c) +: CH_W]}) * w_div[1];
                cp_reg[c][2] <= $signed({1'b0, color_c_reg[CH_W*(NUM_CH-1-c) +: CH_W]}) * w_div[2];
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic [SUM_W-1:0]        rs;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum = SUM_W'(cp_reg[c][0]) + SUM_W'(cp_reg[c][1]) + SUM_W'(cp_reg[c][2]);
            rs  = SUM_W'(sum) + (SUM_W'(1) << (FRAC_BITS - 1));
            if (sum[SUM_W-1])
                ch_next[c] = '0;
            else if (|rs[SUM_W-1:FRAC_BITS+CH_W])
                ch_next[c] = '1;
            else
                ch_next[c] = rs[FRAC_BITS +: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg        <= v_div_reg[DIV_LAT-1];
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_deg_reg <= deg5_reg;
            for (int w = 0; w < 3; w++)
                out_w_reg[w] <= deg5_reg ? '0 : w5_reg[w];
            for (int c = 0; c < NUM_CH; c++)
                out_ch_reg[c] <= deg5_reg ? '0 : ch_next[c];
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_deg_reg;
    assign m_axis_tdata    = OUT_TDATA_W'({out_ch_reg[3], out_ch_reg[2], out_ch_reg[1],
                                           out_ch_reg[0], out_w_reg[2], out_w_reg[1],
                                           out_w_reg[0]});

    `TBS_ASSERT_IMP(a_deg_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
    `TBS_ASSERT_NXT(a_bubble, en && !in_acc, !v1_reg)
    `TBS_ASSERT_NXT(a_stall_hold, !en, v5_reg == $past(v5_reg) && v1_reg == $past(v1_reg))
endmodule
`default_nettype wire
